// ----- rtl/core/mm64b_pkg.sv -----
package mm64b_pkg;

    localparam int WORD_W   = 32;
    localparam int HASH_W   = 64;
    localparam int COUNT_W  = 3;
    localparam int OP_W     = 4;

    localparam logic [WORD_W-1:0] MUL_M = 32'h5bd1e995;

    localparam int MIX_SHIFT = 24;
    localparam int FIN_SH1   = 18;
    localparam int FIN_SH2   = 22;
    localparam int FIN_SH3   = 17;
    localparam int FIN_SH4   = 19;

    localparam logic [OP_W-1:0] OP_NONE   = 4'd0;
    localparam logic [OP_W-1:0] OP_ACCEPT = 4'd1;
    localparam logic [OP_W-1:0] OP_K1     = 4'd2;
    localparam logic [OP_W-1:0] OP_K2     = 4'd3;
    localparam logic [OP_W-1:0] OP_LANE   = 4'd4;
    localparam logic [OP_W-1:0] OP_PART   = 4'd5;
    localparam logic [OP_W-1:0] OP_F1     = 4'd6;
    localparam logic [OP_W-1:0] OP_F2     = 4'd7;
    localparam logic [OP_W-1:0] OP_F3     = 4'd8;
    localparam logic [OP_W-1:0] OP_F4     = 4'd9;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } cmd_t;

    typedef struct packed {
        logic in_restart;
        logic in_full;
        logic in_partial;
        logic in_last;
        logic last;
        logic out_busy;
    } stat_t;

endpackage

// ----- rtl/core/mm64b_ctrl.sv -----
module mm64b_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  mm64b_pkg::stat_t st,
    output mm64b_pkg::cmd_t  cmd
);
    import mm64b_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_K1   = 4'd1;
    localparam logic [3:0] ST_K2   = 4'd2;
    localparam logic [3:0] ST_LANE = 4'd3;
    localparam logic [3:0] ST_PART = 4'd4;
    localparam logic [3:0] ST_F1   = 4'd5;
    localparam logic [3:0] ST_F2   = 4'd6;
    localparam logic [3:0] ST_F3   = 4'd7;
    localparam logic [3:0] ST_F4   = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       xfer;

    assign s_ready = (state_reg == ST_IDLE);
    assign xfer    = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            ST_IDLE: begin
                if (xfer) begin
                    cmd.op = OP_ACCEPT;
                    priority if (st.in_restart) begin
                        state_next = ST_IDLE;
                    end else if (st.in_full) begin
                        state_next = ST_K1;
                    end else if (st.in_partial) begin
                        state_next = ST_PART;
                    end else if (st.in_last) begin
                        state_next = ST_F1;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_K1: begin
                cmd.op     = OP_K1;
                state_next = ST_K2;
            end
            ST_K2: begin
                cmd.op     = OP_K2;
                state_next = ST_LANE;
            end
            ST_LANE: begin
                cmd.op     = OP_LANE;
                state_next = st.last ? ST_F1 : ST_IDLE;
            end
            ST_PART: begin
                cmd.op     = OP_PART;
                state_next = st.last ? ST_F1 : ST_IDLE;
            end
            ST_F1: begin
                cmd.op     = OP_F1;
                state_next = ST_F2;
            end
            ST_F2: begin
                cmd.op     = OP_F2;
                state_next = ST_F3;
            end
            ST_F3: begin
                cmd.op     = OP_F3;
                state_next = ST_F4;
            end
            ST_F4: begin
                if (!st.out_busy) begin
                    cmd.op     = OP_F4;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_full_word_mixes: assert property (@(posedge aclk) disable iff (!aresetn)
        xfer && !st.in_restart && st.in_full |=> state_reg == ST_K1)
        else $error("full word did not start mixing");

    a_restart_stays_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        xfer && st.in_restart |=> state_reg == ST_IDLE)
        else $error("restart left idle");

endmodule

// ----- rtl/core/mm64b_dp.sv -----
module mm64b_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  mm64b_pkg::cmd_t                   cmd,
    output mm64b_pkg::stat_t                  st,
    input  logic                              s_mode,
    input  logic [mm64b_pkg::WORD_W-1:0]      s_data_word,
    input  logic [mm64b_pkg::COUNT_W-1:0]     s_byte_count,
    input  logic [mm64b_pkg::WORD_W-1:0]      s_total_length,
    input  logic                              s_last_word,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [mm64b_pkg::HASH_W-1:0]      cfg_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [mm64b_pkg::HASH_W-1:0]      m_hash_value
);
    import mm64b_pkg::*;

    logic [HASH_W-1:0]  seed_reg,   seed_next;
    logic [HASH_W-1:0]  chain_reg,  chain_next;
    logic [WORD_W-1:0]  lane1_reg,  lane1_next;
    logic [WORD_W-1:0]  lane2_reg,  lane2_next;
    logic [WORD_W-1:0]  tmp_reg,    tmp_next;
    logic [WORD_W-1:0]  word_reg,   word_next;
    logic [1:0]         cnt_reg,    cnt_next;
    logic               last_reg,   last_next;
    logic               par_reg,    par_next;
    logic               open_reg,   open_next;
    logic               oval_reg,   oval_next;
    logic [HASH_W-1:0]  hash_reg,   hash_next;

    logic [WORD_W-1:0]  mul_in;
    logic [WORD_W-1:0]  mul_prod;
    logic [WORD_W-1:0]  part_mask;

    assign st.in_restart = s_mode;
    assign st.in_full    = s_byte_count[2];
    assign st.in_partial = !s_byte_count[2] && (s_byte_count[1:0] != 2'd0);
    assign st.in_last    = s_last_word;
    assign st.last       = last_reg;
    assign st.out_busy   = oval_reg && !m_ready;

    assign m_valid      = oval_reg;
    assign m_hash_value = hash_reg;

    always_comb begin
        unique case (cnt_reg)
            2'd1:    part_mask = 32'h0000_00ff;
            2'd2:    part_mask = 32'h0000_ffff;
            default: part_mask = 32'h00ff_ffff;
        endcase
    end

    // shared constant multiplier, operand picked per step
    always_comb begin
        unique case (cmd.op)
            OP_K1:   mul_in = word_reg;
            OP_K2:   mul_in = tmp_reg ^ (tmp_reg >> MIX_SHIFT);
            OP_LANE: mul_in = par_reg ? lane2_reg : lane1_reg;
            OP_PART: mul_in = lane2_reg ^ (word_reg & part_mask);
            OP_F1:   mul_in = lane1_reg ^ (lane2_reg >> FIN_SH1);
            OP_F2:   mul_in = lane2_reg ^ (lane1_reg >> FIN_SH2);
            OP_F3:   mul_in = lane1_reg ^ (lane2_reg >> FIN_SH3);
            OP_F4:   mul_in = lane2_reg ^ (lane1_reg >> FIN_SH4);
            default: mul_in = '0;
        endcase
    end

    assign mul_prod = mul_in * MUL_M;

    always_comb begin
        seed_next  = seed_reg;
        chain_next = chain_reg;
        lane1_next = lane1_reg;
        lane2_next = lane2_reg;
        tmp_next   = tmp_reg;
        word_next  = word_reg;
        cnt_next   = cnt_reg;
        last_next  = last_reg;
        par_next   = par_reg;
        open_next  = open_reg;
        oval_next  = oval_reg;
        hash_next  = hash_reg;

        if (oval_reg && m_ready) begin
            oval_next = 1'b0;
        end
        if (cfg_valid && cfg_ready) begin
            seed_next = cfg_data;
        end

        unique case (cmd.op)
            OP_ACCEPT: begin
                word_next = s_data_word;
                cnt_next  = s_byte_count[1:0];
                last_next = s_last_word;
                if (s_mode) begin
                    chain_next = seed_reg;
                    lane1_next = '0;
                    lane2_next = '0;
                    par_next   = 1'b0;
                    open_next  = 1'b0;
                end else if (!open_reg) begin
                    lane1_next = chain_reg[WORD_W-1:0] ^ s_total_length;
                    lane2_next = chain_reg[HASH_W-1:WORD_W];
                    par_next   = 1'b0;
                    open_next  = 1'b1;
                end
            end
            OP_K1, OP_K2: begin
                tmp_next = mul_prod;
            end
            OP_LANE: begin
                if (par_reg) begin
                    lane2_next = mul_prod ^ tmp_reg;
                end else begin
                    lane1_next = mul_prod ^ tmp_reg;
                end
                par_next = !par_reg;
            end
            OP_PART, OP_F2: begin
                lane2_next = mul_prod;
            end
            OP_F1, OP_F3: begin
                lane1_next = mul_prod;
            end
            OP_F4: begin
                chain_next = {lane1_reg, mul_prod};
                hash_next  = {lane1_reg, mul_prod};
                oval_next  = 1'b1;
                lane1_next = '0;
                lane2_next = '0;
                par_next   = 1'b0;
                open_next  = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg  <= '0;
            chain_reg <= '0;
            lane1_reg <= '0;
            lane2_reg <= '0;
            par_reg   <= 1'b0;
            open_reg  <= 1'b0;
            oval_reg  <= 1'b0;
        end else begin
            seed_reg  <= seed_next;
            chain_reg <= chain_next;
            lane1_reg <= lane1_next;
            lane2_reg <= lane2_next;
            par_reg   <= par_next;
            open_reg  <= open_next;
            oval_reg  <= oval_next;
        end
    end

    always_ff @(posedge aclk) begin
        tmp_reg  <= tmp_next;
        word_reg <= word_next;
        cnt_reg  <= cnt_next;
        last_reg <= last_next;
        hash_reg <= hash_next;
    end

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_F4 |-> !(oval_reg && !m_ready))
        else $error("result overwritten before transfer");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(oval_reg) |-> $past(cmd.op == OP_F4))
        else $error("result without finalization");

    a_close_after_final: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_F4 |=> !open_reg && !par_reg && chain_reg == hash_reg)
        else $error("message not closed after finalization");

endmodule

// ----- rtl/core/murmur64b_stream_hash_top.sv -----
// Streaming MurmurHash64B over little-endian 32-bit words with a chained seed.
// Items are taken one at a time and all hashing runs through a single
// 32-bit constant multiplier. A full word takes the transfer and three
// multiplier passes, a partial word the transfer and a masked mix pass,
// a restart or empty non-last word the transfer alone. The last word of
// a message adds the finalization passes, the last of them waiting while
// the output register holds an earlier result. The result seeds the next
// message; a restart reloads it from the seed register the cfg port writes.
module murmur64b_stream_hash_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_mode,
    input  logic [mm64b_pkg::WORD_W-1:0]      s_data_word,
    input  logic [mm64b_pkg::COUNT_W-1:0]     s_byte_count,
    input  logic [mm64b_pkg::WORD_W-1:0]      s_total_length,
    input  logic                              s_last_word,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [mm64b_pkg::HASH_W-1:0]      m_hash_value,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mm64b_pkg::HASH_W-1:0]      cfg_data
);
    import mm64b_pkg::*;

    cmd_t  cmd;
    stat_t st;

    assign cfg_ready = 1'b1;

    mm64b_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    mm64b_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .st             (st),
        .s_mode         (s_mode),
        .s_data_word    (s_data_word),
        .s_byte_count   (s_byte_count),
        .s_total_length (s_total_length),
        .s_last_word    (s_last_word),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hash_value   (m_hash_value)
    );

endmodule
